// ===== sv/dbc_pkg.sv =====
package dbc_pkg;

  // Default field geometry: unsigned Q2.18 masses squared.
  localparam int unsigned FracBits  = 18;
  localparam int unsigned MassWidth = 20;

  // Register map, index i at byte address 4*i.
  localparam int unsigned RegCount  = 5;
  localparam int unsigned AddrWidth = 5;

  typedef enum logic [2:0] {
    REG_PARENT = 3'd0,
    REG_HEAVY  = 3'd1,
    REG_LIGHT  = 3'd2,
    REG_LOWER  = 3'd3,
    REG_UPPER  = 3'd4
  } reg_idx_t;

  // Reset values of the registers.
  localparam logic [31:0] ParentReset = 32'd911641;
  localparam logic [31:0] HeavyReset  = 32'd64912;
  localparam logic [31:0] LightReset  = 32'd5107;
  localparam logic [31:0] LowerReset  = 32'd106431;
  localparam logic [31:0] UpperReset  = 32'd780285;

endpackage

// ===== sv/dbc_stream_if.sv =====
interface dbc_stream_if #(
  parameter int unsigned Width = 1
) (
  input logic clk
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/dbc_isqrt.sv =====
// Pipelined floor square root, one result bit per stage.
// Each stage carries a valid bit and its own payload; enable stalls all stages.
module dbc_isqrt #(
  parameter int unsigned InWidth  = 70,
  parameter int unsigned TagWidth = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [InWidth-1:0]        in_x,
  input  logic [TagWidth-1:0]       in_tag,
  output logic                      out_valid,
  output logic [(InWidth+1)/2-1:0]  out_root,
  output logic [TagWidth-1:0]       out_tag
);
  localparam int unsigned RootWidth = (InWidth + 1) / 2;
  localparam int unsigned XWidth    = 2 * RootWidth;

  logic [RootWidth:0]       vld;
  logic [XWidth-1:0]        rem  [RootWidth+1];
  logic [RootWidth-1:0]     root [RootWidth+1];
  logic [XWidth-1:0]        xs   [RootWidth+1];
  logic [TagWidth-1:0]      tag  [RootWidth+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = XWidth'(in_x);
  assign tag[0]  = in_tag;

  // Restoring digit recurrence; stage k decides root bit RootWidth-1-k.
  for (genvar k = 0; k < RootWidth; k++) begin : g_stage
    logic [XWidth+1:0] trial;
    logic [XWidth+1:0] cur;
    assign cur   = {rem[k], xs[k][XWidth-1 -: 2]};
    assign trial = cur - {root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1]  <= xs[k] << 2;
        tag[k+1] <= tag[k];
        if (!trial[XWidth+1]) begin
          rem[k+1]  <= trial[XWidth-1:0];
          root[k+1] <= {root[k][RootWidth-2:0], 1'b1};
        end else begin
          rem[k+1]  <= cur[XWidth-1:0];
          root[k+1] <= {root[k][RootWidth-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[RootWidth];
  assign out_root  = root[RootWidth];
  assign out_tag   = tag[RootWidth];
endmodule

// ===== sv/dbc_divide.sv =====
// Pipelined signed floor division of a magnitude by a positive divisor,
// one quotient bit per stage, followed by base addition and clamping.
module dbc_divide #(
  parameter int unsigned NumWidth  = 72,
  parameter int unsigned DenWidth  = 34,
  parameter int unsigned MassWidth = 20,
  parameter int unsigned TagWidth  = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic                 in_neg,
  input  logic [NumWidth-1:0]  in_mag,
  input  logic [DenWidth-1:0]  in_den,
  input  logic [MassWidth:0]   in_base,
  input  logic [TagWidth-1:0]  in_tag,
  output logic                 out_valid,
  output logic [MassWidth-1:0] out_bound,
  output logic [TagWidth-1:0]  out_tag
);
  localparam int unsigned SatBit = 2 * MassWidth;

  logic [NumWidth:0]     vld;
  logic [DenWidth:0]     rem  [NumWidth+1];
  logic [NumWidth-1:0]   quo  [NumWidth+1];
  logic [NumWidth-1:0]   num  [NumWidth+1];
  logic [DenWidth-1:0]   den  [NumWidth+1];
  logic                  neg  [NumWidth+1];
  logic [MassWidth:0]    base [NumWidth+1];
  logic [TagWidth-1:0]   tag  [NumWidth+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign quo[0]  = '0;
  assign num[0]  = in_mag;
  assign den[0]  = in_den;
  assign neg[0]  = in_neg;
  assign base[0] = in_base;
  assign tag[0]  = in_tag;

  // Long division, most significant numerator bit first.
  for (genvar k = 0; k < NumWidth; k++) begin : g_stage
    logic [DenWidth+1:0] shifted;
    logic [DenWidth+1:0] diff;
    assign shifted = {rem[k], num[k][NumWidth-1]};
    assign diff    = shifted - {2'b00, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1]  <= num[k] << 1;
        den[k+1]  <= den[k];
        neg[k+1]  <= neg[k];
        base[k+1] <= base[k];
        tag[k+1]  <= tag[k];
        if (!diff[DenWidth+1]) begin
          rem[k+1] <= diff[DenWidth:0];
          quo[k+1] <= {quo[k][NumWidth-2:0], 1'b1};
        end else begin
          rem[k+1] <= shifted[DenWidth:0];
          quo[k+1] <= {quo[k][NumWidth-2:0], 1'b0};
        end
      end
    end
  end

  // Saturate the quotient, round toward minus infinity, add base, clamp.
  logic [NumWidth-1:0] q;
  logic [SatBit:0]     qsat;
  logic [SatBit+1:0]   qm;
  logic [SatBit+2:0]   sum;
  logic                fin_vld;
  logic [MassWidth-1:0] fin_bound;
  logic [TagWidth-1:0]  fin_tag;

  assign q = quo[NumWidth];

  always_comb begin
    if ((q >> SatBit) != '0) begin
      qsat = {1'b1, {SatBit{1'b0}}};
    end else begin
      qsat = q[SatBit:0];
    end
    qm = {1'b0, qsat} + {{(SatBit+1){1'b0}}, (neg[NumWidth] && rem[NumWidth] != '0)};
    if (neg[NumWidth]) begin
      sum = {{(SatBit+2-MassWidth){1'b0}}, base[NumWidth]} - {1'b0, qm};
    end else begin
      sum = {{(SatBit+2-MassWidth){1'b0}}, base[NumWidth]} + {1'b0, qm};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else if (en) begin
      fin_vld <= vld[NumWidth];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_tag <= tag[NumWidth];
      if (sum[SatBit+2]) begin
        fin_bound <= '0;
      end else if ((sum >> MassWidth) != '0) begin
        fin_bound <= '1;
      end else begin
        fin_bound <= sum[MassWidth-1:0];
      end
    end
  end

  assign out_valid = fin_vld;
  assign out_bound = fin_bound;
  assign out_tag   = fin_tag;
endmodule

// ===== sv/dalitz_boundary_check.sv =====
// Channel   | Dir | Payload                                         | Handshake
// in_pt     | in  | first_pair_sq, second_pair_sq                   | valid/ready
// out_res   | out | inside_res, first_in_range, bound_low, bound_high | valid/ready
// apb       | in  | five mass registers at byte address 4*i          | psel/penable
//
// One point enters per cycle unless the output stalls. The pipeline holds
// 4 front stages, a 23-stage square root, a product stage and a sum stage,
// a 48-stage divider with one clamp stage, and one output stage. The whole
// pipeline advances only when the output register is empty or being taken,
// so a stall holds every request in place.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
module dalitz_boundary_check #(
  parameter int unsigned MASS_WIDTH = dbc_pkg::MassWidth
) (
  input  logic                         clk,
  input  logic                         rst,
  dbc_stream_if.sink                   in_pt,
  dbc_stream_if.source                 out_res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dbc_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  localparam int unsigned W     = MASS_WIDTH;
  localparam int unsigned SW    = W + 3;            // signed A, B
  localparam int unsigned LW    = 2 * W + 6;        // LA, LB
  localparam int unsigned RW    = LW / 2;           // roots
  localparam int unsigned NW    = 2 * W + 8;        // |A*B +/- R|
  localparam int unsigned DW    = W + 1;            // 2*S1
  localparam int unsigned TW    = 2 * W + 4;        // carried payload

  // Configuration registers.
  logic [W-1:0] parent_sq, heavy_sq, light_sq, lower_lim, upper_lim;
  logic         wr_en;
  logic [2:0]   wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      parent_sq <= dbc_pkg::ParentReset[W-1:0];
      heavy_sq  <= dbc_pkg::HeavyReset[W-1:0];
      light_sq  <= dbc_pkg::LightReset[W-1:0];
      lower_lim <= dbc_pkg::LowerReset[W-1:0];
      upper_lim <= dbc_pkg::UpperReset[W-1:0];
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (wr_idx)
        dbc_pkg::REG_PARENT: parent_sq <= pwdata[W-1:0];
        dbc_pkg::REG_HEAVY:  heavy_sq  <= pwdata[W-1:0];
        dbc_pkg::REG_LIGHT:  light_sq  <= pwdata[W-1:0];
        dbc_pkg::REG_LOWER:  lower_lim <= pwdata[W-1:0];
        dbc_pkg::REG_UPPER:  upper_lim <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (wr_idx)
        dbc_pkg::REG_PARENT: prdata = 32'(parent_sq);
        dbc_pkg::REG_HEAVY:  prdata = 32'(heavy_sq);
        dbc_pkg::REG_LIGHT:  prdata = 32'(light_sq);
        dbc_pkg::REG_LOWER:  prdata = 32'(lower_lim);
        dbc_pkg::REG_UPPER:  prdata = 32'(upper_lim);
        default:             prdata = '0;
      endcase
    end
  end

  // Global advance: output register empty or being taken.
  logic en;
  logic out_vld;
  assign en          = !out_vld || out_res.ready;
  assign in_pt.ready = en;

  logic [W-1:0] s1_in, s2_in;
  assign s1_in = in_pt.data[2*W-1:W];
  assign s2_in = in_pt.data[W-1:0];

  // Stage 1: range check, A and B.
  logic               v1, go1, rng1;
  logic signed [SW-1:0] a1, b1;
  logic [W-1:0]       s1_1, s2_1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_pt.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rng1 <= (s1_in >= lower_lim) && (s1_in <= upper_lim);
      go1  <= (s1_in >= lower_lim) && (s1_in <= upper_lim) && (s1_in != '0);
      a1   <= SW'(s1_in) + SW'(heavy_sq) - SW'(light_sq);
      b1   <= SW'(parent_sq) - SW'(s1_in) - SW'(light_sq);
      s1_1 <= s1_in;
      s2_1 <= s2_in;
    end
  end

  // Stage 2: magnitudes and signs.
  logic          v2, go2, rng2, abneg2;
  logic [SW-1:0] am2, bm2;
  logic [W-1:0]  s1_2, s2_2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      go2    <= go1;
      rng2   <= rng1;
      am2    <= a1[SW-1] ? SW'(-a1) : SW'(a1);
      bm2    <= b1[SW-1] ? SW'(-b1) : SW'(b1);
      abneg2 <= a1[SW-1] ^ b1[SW-1];
      s1_2   <= s1_1;
      s2_2   <= s2_1;
    end
  end

  // Stage 3: the five squares and products, one multiply each.
  logic          v3, go3, rng3, abneg3;
  logic [LW-1:0] a2_3, b2_3, ka3, kb3, ab3;
  logic [W-1:0]  s1_3, s2_3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      go3    <= go2;
      rng3   <= rng2;
      abneg3 <= abneg2;
      a2_3   <= LW'(am2) * LW'(am2);
      b2_3   <= LW'(bm2) * LW'(bm2);
      ab3    <= LW'(am2) * LW'(bm2);
      ka3    <= (LW'(s1_2) * LW'(heavy_sq)) << 2;
      kb3    <= (LW'(s1_2) * LW'(light_sq)) << 2;
      s1_3   <= s1_2;
      s2_3   <= s2_2;
    end
  end

  // Stage 4: momentum terms, physical check.
  logic          v4, go4, rng4, abneg4;
  logic [LW-1:0] la4, lb4, ab4;
  logic [W-1:0]  s1_4, s2_4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      go4    <= go3 && (a2_3 >= ka3) && (b2_3 >= kb3);
      rng4   <= rng3;
      abneg4 <= abneg3;
      la4    <= a2_3 - ka3;
      lb4    <= b2_3 - kb3;
      ab4    <= ab3;
      s1_4   <= s1_3;
      s2_4   <= s2_3;
    end
  end

  // Square roots of both momentum terms; the side payload rides in the tag.
  localparam int unsigned QW = LW + 2 * W + 3;
  logic [QW-1:0]  tag_in, tag_out, tag_unused;
  logic           vs, vs_b;
  logic [RW-1:0]  ra, rb;
  assign tag_in = {go4, rng4, abneg4, ab4, s1_4, s2_4};

  dbc_isqrt #(.InWidth(LW), .TagWidth(QW)) u_sqrt_a (
    .clk, .rst, .en,
    .in_valid(v4), .in_x(la4), .in_tag(tag_in),
    .out_valid(vs), .out_root(ra), .out_tag(tag_out)
  );
  dbc_isqrt #(.InWidth(LW), .TagWidth(QW)) u_sqrt_b (
    .clk, .rst, .en,
    .in_valid(v4), .in_x(lb4), .in_tag(tag_in),
    .out_valid(vs_b), .out_root(rb), .out_tag(tag_unused)
  );

  logic          go5, rng5, abneg5;
  logic [LW-1:0] ab5;
  logic [W-1:0]  s1_5, s2_5;
  assign {go5, rng5, abneg5, ab5, s1_5, s2_5} = tag_out;

  // Stage 6: R = ra * rb.
  logic          v6, go6, rng6, abneg6;
  logic [NW-1:0] r6, ab6;
  logic [W-1:0]  s1_6, s2_6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= vs && vs_b;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      go6    <= go5;
      rng6   <= rng5;
      abneg6 <= abneg5;
      r6     <= NW'(NW'(ra) * NW'(rb));
      ab6    <= NW'(ab5);
      s1_6   <= s1_5;
      s2_6   <= s2_5;
    end
  end

  // Stage 7: signed sums A*B - R and A*B + R as sign and magnitude.
  logic          v7, go7, rng7, nlo7, nhi7;
  logic [NW-1:0] mlo7, mhi7;
  logic [W-1:0]  s1_7, s2_7;
  logic [W:0]    base7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      go7   <= go6;
      rng7  <= rng6;
      s1_7  <= s1_6;
      s2_7  <= s2_6;
      base7 <= (W+1)'(heavy_sq) + (W+1)'(light_sq);
      if (abneg6) begin
        nlo7 <= 1'b1;
        mlo7 <= ab6 + r6;
        nhi7 <= (ab6 > r6);
        mhi7 <= (ab6 > r6) ? ab6 - r6 : r6 - ab6;
      end else begin
        nhi7 <= 1'b0;
        mhi7 <= ab6 + r6;
        nlo7 <= (r6 > ab6);
        mlo7 <= (ab6 >= r6) ? ab6 - r6 : r6 - ab6;
      end
    end
  end

  // Dividers for both bounds.
  localparam int unsigned DTW = 2 * W + 2;
  logic            vd_lo, vd_hi;
  logic [W-1:0]    blo, bhi;
  logic [DTW-1:0]  dtag_in, dtag_out, dtag_unused;
  logic [DW-1:0]   den7;
  assign den7    = {s1_7, 1'b0};
  assign dtag_in = {go7, rng7, s2_7, s1_7};

  dbc_divide #(.NumWidth(NW), .DenWidth(DW), .MassWidth(W), .TagWidth(DTW)) u_div_lo (
    .clk, .rst, .en,
    .in_valid(v7), .in_neg(nlo7), .in_mag(mlo7), .in_den(den7), .in_base(base7),
    .in_tag(dtag_in), .out_valid(vd_lo), .out_bound(blo), .out_tag(dtag_out)
  );
  dbc_divide #(.NumWidth(NW), .DenWidth(DW), .MassWidth(W), .TagWidth(DTW)) u_div_hi (
    .clk, .rst, .en,
    .in_valid(v7), .in_neg(nhi7), .in_mag(mhi7), .in_den(den7), .in_base(base7),
    .in_tag(dtag_in), .out_valid(vd_hi), .out_bound(bhi), .out_tag(dtag_unused)
  );

  logic         god, rngd;
  logic [W-1:0] s2d, s1d;
  assign {god, rngd, s2d, s1d} = dtag_out;

  // Output register.
  logic         o_inside, o_rng;
  logic [W-1:0] o_lo, o_hi;
  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (en) out_vld <= vd_lo && vd_hi;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_rng    <= rngd;
      o_inside <= god && (s2d >= blo) && (s2d <= bhi) && (s1d != '0);
      o_lo     <= god ? blo : '0;
      o_hi     <= god ? bhi : '0;
    end
  end

  assign out_res.valid = out_vld;
  assign out_res.data  = {o_inside, o_rng, o_lo, o_hi};
endmodule

// ===== sv/dbc_checker.sv =====
// Port-level checks for the boundary checker.
module dbc_checker #(
  parameter int unsigned W = dbc_pkg::MassWidth
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2*W+1:0]   out_data,
  input logic             in_ready
);
  // A pending result holds until taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Inside implies first mass in range.
  a_in_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[2*W+1] |-> out_data[2*W])
    else $error("inside without range");

  // Inside implies ordered bounds.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[2*W+1] |-> out_data[2*W-1:W] <= out_data[W-1:0])
    else $error("bounds out of order");

  // Input is taken whenever the output side is free.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("stalled with empty output");
endmodule

bind dalitz_boundary_check dbc_checker #(.W(MASS_WIDTH)) u_dbc_checker (
  .clk(clk), .rst(rst), .out_valid(out_res.valid), .out_ready(out_res.ready),
  .out_data(out_res.data), .in_ready(in_pt.ready)
);
